// ----- design/complex_magnitude_unit_macros.svh -----
// Assertion macros shared by the complex magnitude unit.
// No dependencies; pulled in by the modules that carry checks.
`ifndef COMPLEX_MAGNITUDE_UNIT_MACROS_SVH
`define COMPLEX_MAGNITUDE_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CMAG_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cmag check failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define CMAG_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cmag check failed: next-cycle implication");

`endif

// ----- design/cmag_pkg.sv -----
// Shared constants for the complex magnitude unit.
// No dependencies.
`timescale 1ns / 1ps

package cmag_pkg;

  // result field
  localparam int MAG_W = 16;
  localparam logic [MAG_W-1:0] MAG_MAX = 16'hFFFF;

  // widest root the sample width range can produce (SAMPLE_WIDTH 32 -> 33 bits)
  localparam int ROOT_EXT_W = 33;

endpackage

// ----- design/cmag_square.sv -----
// Sum-of-squares front end: absolute value, squares, sum (three stages).
// Depends on cmag_pkg.
`timescale 1ns / 1ps

module cmag_square #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [SAMPLE_WIDTH-1:0] in_real,
  input  logic [SAMPLE_WIDTH-1:0] in_imag,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [2*SAMPLE_WIDTH:0] out_sum
);
  import cmag_pkg::*;

  localparam int PROD_W = 2 * SAMPLE_WIDTH;
  localparam int SUM_W  = PROD_W + 1;
  localparam logic [SAMPLE_WIDTH-1:0] ONE = SAMPLE_WIDTH'(1);

  logic                    v0, v1, v2;
  logic                    rdy0, rdy1, rdy2;
  logic [SAMPLE_WIDTH-1:0] abs_re, abs_im;
  logic [SAMPLE_WIDTH-1:0] abs_re_q, abs_im_q;
  logic [PROD_W-1:0]       sq_re_q, sq_im_q;
  logic [SUM_W-1:0]        sum_q;

  // most negative value negates to 2^(W-1), exact as unsigned
  assign abs_re = in_real[SAMPLE_WIDTH-1] ? (~in_real + ONE) : in_real;
  assign abs_im = in_imag[SAMPLE_WIDTH-1] ? (~in_imag + ONE) : in_imag;

  assign rdy2 = !v2 || out_ready;
  assign rdy1 = !v1 || rdy2;
  assign rdy0 = !v0 || rdy1;
  assign in_ready = rdy0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (rdy0) v0 <= in_valid;
      if (rdy1) v1 <= v0;
      if (rdy2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0 && in_valid) begin
      abs_re_q <= abs_re;
      abs_im_q <= abs_im;
    end
    if (rdy1 && v0) begin
      sq_re_q <= PROD_W'(abs_re_q) * PROD_W'(abs_re_q);
      sq_im_q <= PROD_W'(abs_im_q) * PROD_W'(abs_im_q);
    end
    if (rdy2 && v1) begin
      sum_q <= SUM_W'(sq_re_q) + SUM_W'(sq_im_q);
    end
  end

  assign out_valid = v2;
  assign out_sum   = sum_q;

endmodule

// ----- design/cmag_sqrt.sv -----
// Pipelined restoring integer square root, one root bit per stage.
// Depends on cmag_pkg and complex_magnitude_unit_macros.svh.
`timescale 1ns / 1ps
`include "complex_magnitude_unit_macros.svh"

module cmag_sqrt #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [2*SAMPLE_WIDTH:0] in_sum,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [SAMPLE_WIDTH:0]   out_root
);
  import cmag_pkg::*;

  localparam int ROOT_W = SAMPLE_WIDTH + 1;
  localparam int SQ_W   = 2 * ROOT_W;   // radicand padded to whole bit pairs
  localparam int REM_W  = ROOT_W + 3;

  logic [ROOT_W-1:0] vq;
  logic [ROOT_W:0]   rdy;
  logic [REM_W-1:0]  rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  logic [SQ_W-1:0]   n_q    [ROOT_W];

  assign rdy[ROOT_W] = out_ready;
  assign in_ready    = rdy[0];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic              v_in;
    logic [REM_W-1:0]  rem_in, rem_sh, trial;
    logic [ROOT_W-1:0] root_in;
    logic [SQ_W-1:0]   n_in;
    logic              fit;

    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = '0;
      assign root_in = '0;
      assign n_in    = SQ_W'(in_sum);
    end else begin : g_next
      assign v_in    = vq[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign n_in    = n_q[k-1];
    end

    // bring down the next two radicand bits, try root*4+1
    assign rem_sh = {rem_in[REM_W-3:0], n_in[SQ_W-1 -: 2]};
    assign trial  = REM_W'({root_in, 2'b01});
    assign fit    = rem_sh >= trial;

    assign rdy[k] = !vq[k] || rdy[k+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        vq[k] <= 1'b0;
      end else if (rdy[k]) begin
        vq[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && v_in) begin
        rem_q[k]  <= fit ? (rem_sh - trial) : rem_sh;
        root_q[k] <= {root_in[ROOT_W-2:0], fit};
        n_q[k]    <= {n_in[SQ_W-3:0], 2'b00};
      end
    end
  end

  assign out_valid = vq[ROOT_W-1];
  assign out_root  = root_q[ROOT_W-1];

  // remainder of a floor root never exceeds twice the root
  `CMAG_ASSERT_IMP(a_rem_bound, clk, rst, vq[ROOT_W-1], rem_q[ROOT_W-1] <= REM_W'({root_q[ROOT_W-1], 1'b0}))
  // a finished root held back by the consumer stays put
  `CMAG_ASSERT_NXT(a_out_hold, clk, rst, vq[ROOT_W-1] && !out_ready, vq[ROOT_W-1] && $stable(root_q[ROOT_W-1]))
  // an accepted radicand always lands in the first stage
  `CMAG_ASSERT_NXT(a_enter, clk, rst, in_valid && rdy[0], vq[0])

endmodule

// ----- design/complex_magnitude_unit.sv -----
// Complex magnitude unit top level: floor(sqrt(re^2 + im^2)) per transaction.
// Depends on cmag_pkg, cmag_square, cmag_sqrt.
`timescale 1ns / 1ps
//
//  channel   | dir | signals                  | payload
//  ----------+-----+--------------------------+----------------------------------
//  s_axis    | in  | s_tvalid/s_tready/tdata  | real_part, imag_part (SAMPLE_WIDTH)
//  m_axis    | out | m_tvalid/m_tready/tdata  | magnitude (16 bits, unsigned)
//
//  Throughput: one transaction per clock, sustained while m_tready is held high.
//  Pipeline: three stages for abs/square/sum, then one stage per root bit in the
//    square root pipeline.
//  Reset (rst, synchronous) empties the pipeline; payload registers are not cleared.
//  Stalls: a full stage holds while its successor cannot accept, so bubbles collapse and
//    input is still taken while a finished result waits on m_tready, as long as a stage is empty.

module complex_magnitude_unit #(
  parameter int SAMPLE_WIDTH = 16   // width of each part, 8..32
) (
  input  logic clk,
  input  logic rst,

  input  logic s_tvalid,
  output logic s_tready,
  // [SAMPLE_WIDTH-1:0] real_part, [2*SAMPLE_WIDTH-1:SAMPLE_WIDTH] imag_part, zero pad above
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,

  output logic m_tvalid,
  input  logic m_tready,
  // [15:0] magnitude
  output logic [cmag_pkg::MAG_W-1:0] m_tdata
);
  import cmag_pkg::*;

  localparam int ROOT_W = SAMPLE_WIDTH + 1;
  localparam int SUM_W  = 2 * SAMPLE_WIDTH + 1;

  logic                    sq_valid, sq_ready;
  logic [SUM_W-1:0]        sq_sum;
  logic [ROOT_W-1:0]       root;
  logic [ROOT_EXT_W-1:0]   root_ext;

  // stages 1..3: |re|, |im| -> squares -> sum of squares
  cmag_square #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_square (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_real  (s_tdata[SAMPLE_WIDTH-1:0]),
    .in_imag  (s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
    .out_valid(sq_valid),
    .out_ready(sq_ready),
    .out_sum  (sq_sum)
  );

  // remaining stages: one root bit each; last stage is the output register
  cmag_sqrt #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sq_valid),
    .in_ready (sq_ready),
    .in_sum   (sq_sum),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_root (root)
  );

  // roots above 16 bits only occur for wide samples; clamp to full scale
  assign root_ext = ROOT_EXT_W'(root);
  assign m_tdata  = (root_ext > ROOT_EXT_W'(MAG_MAX)) ? MAG_MAX : root_ext[MAG_W-1:0];

endmodule
